### sv/psfg_pkg.sv
`default_nettype none

package psfg_pkg;

	// Coordinate, phase and sine table geometry.
	localparam int COORD_BITS       = 12;
	localparam int PHASE_BITS       = 16;
	localparam int SINE_TABLE_DEPTH = 1024;

	// Derived widths.
	localparam int PROD_BITS     = 2 * COORD_BITS;
	localparam int IN_BITS       = 2 * COORD_BITS;
	localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
	localparam int LEVEL_BITS    = 8;
	localparam int OUT_TDATA_BITS = 3 * LEVEL_BITS;
	localparam int IDX_BITS      = $clog2(SINE_TABLE_DEPTH);
	localparam int QUARTER       = SINE_TABLE_DEPTH / 4;
	localparam int QADDR_BITS    = IDX_BITS - 2;
	localparam int NUM_DIV       = PROD_BITS + PHASE_BITS;

	// Fringe level constants.
	localparam int unsigned LEVEL_MID = 122;
	localparam int unsigned AMPLITUDE = 122;
	localparam int MAG_BITS = $clog2(AMPLITUDE + 1);
	localparam longint unsigned HALF_PI_Q30   = 64'd1686629713;
	localparam longint unsigned ROUND_BIAS_Q30 = 64'd4096;

	// One third of a cycle in phase units, rounded.
	localparam longint unsigned THIRD = ((64'd1 << PHASE_BITS) + 64'd1) / 64'd3;

	// Register reset values.
	localparam logic                  AXIS_SELECT_RST   = 1'b1;
	localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RST  = COORD_BITS'(1024);
	localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RST = COORD_BITS'(768);
	localparam logic [COORD_BITS-1:0] PERIOD_COUNT_RST  = COORD_BITS'(16);

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_AXIS_SELECT   = 2'd0,
		REG_SCREEN_WIDTH  = 2'd1,
		REG_SCREEN_HEIGHT = 2'd2,
		REG_PERIOD_COUNT  = 2'd3
	} cfg_reg_t;

	typedef logic [MAG_BITS-1:0] mag_t;
	typedef logic [QUARTER-1:0][MAG_BITS-1:0] qtab_t;

	// Magnitude of sine in Q30 for an angle in Q30 between zero and a quarter turn,
	// from a Taylor series to degree fifteen. Each term divides the previous one by
	// the next two factorial factors, with signs alternating from a positive x term.
	function automatic longint unsigned sine_mag_q30(longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		x2   = (x * x) >> 30;
		term = x;
		pos  = x;
		neg  = 64'd0;
		term = ((term * x2) >> 30) / 64'd6;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 64'd20;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 64'd42;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 64'd72;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 64'd110;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 64'd156;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 64'd210;
		neg  = neg + term;
		return (pos > neg) ? (pos - neg) : 64'd0;
	endfunction

	// Scaled magnitude for quarter-wave index q (zero up to QUARTER).
	function automatic mag_t sine_level(int unsigned q);
		longint unsigned a4;
		longint unsigned x;
		longint unsigned v;
		a4 = 64'(4 * q);
		x  = (HALF_PI_Q30 * a4) / SINE_TABLE_DEPTH;
		v  = (64'(AMPLITUDE) * sine_mag_q30(x) + ROUND_BIAS_Q30) >> 30;
		if (v > 64'(AMPLITUDE)) begin
			v = 64'(AMPLITUDE);
		end
		return MAG_BITS'(v);
	endfunction

	// Quarter-wave magnitude table without its last point.
	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int q = 0; q < QUARTER; q++) begin
			t[q] = sine_level(q);
		end
		return t;
	endfunction

	localparam qtab_t SINE_QTAB = build_qtab();
	localparam mag_t  SINE_PEAK = sine_level(QUARTER);

endpackage

`default_nettype wire

### sv/phase_shift_fringe_generator.sv
`default_nettype none

// Three-step phase-shift fringe generator. Each input transaction carries one pixel's
// column and row; each output transaction carries the red, green and blue levels
// 122 + trunc(122*sin) at the pixel phase minus a third of a cycle, at the phase,
// and plus a third of a cycle. The block takes one pixel every clock cycle unless the
// output stalls; each pixel passes through the period multiply register, a fully
// pipelined restoring divider (24 steps reduce the product modulo the axis length,
// 16 more produce the phase fraction), and the phase offset, quarter-wave sine table
// and output registers.
// Backpressure on the output stalls the whole pipeline in place. Configuration is
// written through cfg_we, cfg_addr and cfg_data and must only change while no pixel
// is in flight; there is no clearing pass after reset.
module phase_shift_fringe_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write port.
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_addr,
	input  wire logic [psfg_pkg::COORD_BITS-1:0]     cfg_data,
	// Pixel input: column (low bits), row.
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [psfg_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
	// Fringe output: red_level (low bits), green_level, blue_level.
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [psfg_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata
);
	import psfg_pkg::*;

	localparam int NUM_CH    = 3;
	localparam int HALF_BITS = IDX_BITS - 1;

	// Configuration registers.
	logic                  axis_select_q;
	logic [COORD_BITS-1:0] screen_width_q;
	logic [COORD_BITS-1:0] screen_height_q;
	logic [COORD_BITS-1:0] period_count_q;

	// Pipeline control.
	logic en;
	logic [COORD_BITS-1:0] len;

	// Stage 1: period product.
	logic                  vld_s1;
	logic [PROD_BITS-1:0]  prod_s1;
	logic [COORD_BITS-1:0] pos;

	// Divider stages.
	logic                  dv_vld_s  [NUM_DIV];
	logic [COORD_BITS-1:0] dv_rem_s  [NUM_DIV];
	logic [PROD_BITS-1:0]  dv_prod_s [NUM_DIV];
	logic [PHASE_BITS-1:0] dv_quo_s  [NUM_DIV];

	// Phase, table and output stages.
	logic                  phase;
	logic [PHASE_BITS-1:0] base_phase;
	logic                  vld_s2;
	logic                  vld_s3;
	logic                  vld_s4;
	logic                  neg_s2   [NUM_CH];
	logic                  peak_s2  [NUM_CH];
	logic [QADDR_BITS-1:0] qaddr_s2 [NUM_CH];
	logic                  neg_s3   [NUM_CH];
	mag_t                  mag_s3   [NUM_CH];
	logic [LEVEL_BITS-1:0] level_s4 [NUM_CH];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_select_q   <= AXIS_SELECT_RST;
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
			period_count_q  <= PERIOD_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_AXIS_SELECT:   axis_select_q   <= cfg_data[0];
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				REG_PERIOD_COUNT:  period_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a finished result is held at the output.
	assign en            = !vld_s4 || m_axis_tready;
	assign s_axis_tready = en;
	assign len           = axis_select_q ? screen_width_q : screen_height_q;

	// Stage 1: pick the coordinate along the axis and multiply by the period count.
	assign pos = axis_select_q ? s_axis_tdata[COORD_BITS-1:0]
	                           : s_axis_tdata[IN_BITS-1:COORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_BITS'(period_count_q) * PROD_BITS'(pos);
		end
	end

	// Restoring divider: the first steps take the product bits and leave the
	// remainder modulo the axis length; the later steps shift in zeros and collect
	// the phase fraction bits.
	for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
		logic                  v_in;
		logic [COORD_BITS-1:0] rem_in;
		logic [PROD_BITS-1:0]  prod_in;
		logic [PHASE_BITS-1:0] quo_in;
		logic                  next_bit;
		logic [COORD_BITS:0]   trial;
		logic [COORD_BITS:0]   diff;
		logic                  ge;

		if (k == 0) begin : g_first
			assign v_in    = vld_s1;
			assign rem_in  = '0;
			assign prod_in = prod_s1;
			assign quo_in  = '0;
		end else begin : g_next
			assign v_in    = dv_vld_s[k-1];
			assign rem_in  = dv_rem_s[k-1];
			assign prod_in = dv_prod_s[k-1];
			assign quo_in  = dv_quo_s[k-1];
		end

		if (k < PROD_BITS) begin : g_mod_bit
			assign next_bit = prod_in[PROD_BITS-1-k];
		end else begin : g_frac_bit
			assign next_bit = 1'b0;
		end

		assign trial = {rem_in, next_bit};
		assign diff  = trial - {1'b0, len};
		assign ge    = (trial >= {1'b0, len});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k]  <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
				dv_prod_s[k] <= prod_in;
			end
		end

		if (k < PROD_BITS) begin : g_quo_hold
			always_ff @(posedge clk) begin
				if (en) begin
					dv_quo_s[k] <= quo_in;
				end
			end
		end else begin : g_quo_shift
			always_ff @(posedge clk) begin
				if (en) begin
					dv_quo_s[k] <= {quo_in[PHASE_BITS-2:0], ge};
				end
			end
		end
	end

	// A zero axis length leaves the base phase at zero.
	assign phase      = (len != '0);
	assign base_phase = phase ? dv_quo_s[NUM_DIV-1] : '0;

	// Stage 2: apply the one-third phase offsets and fold each phase onto a quarter wave.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_fold
		logic [PHASE_BITS-1:0] ch_phase;
		logic [IDX_BITS-1:0]   idx;
		logic [HALF_BITS-1:0]  half;
		logic [HALF_BITS-1:0]  q;

		if (c == 0) begin : g_red
			assign ch_phase = base_phase - PHASE_BITS'(THIRD);
		end else if (c == 1) begin : g_green
			assign ch_phase = base_phase;
		end else begin : g_blue
			assign ch_phase = base_phase + PHASE_BITS'(THIRD);
		end

		assign idx  = ch_phase[PHASE_BITS-1 -: IDX_BITS];
		assign half = idx[HALF_BITS-1:0];
		assign q    = (half > HALF_BITS'(QUARTER)) ? (HALF_BITS'(0) - half) : half;

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s2[c]   <= idx[IDX_BITS-1];
				peak_s2[c]  <= (q == HALF_BITS'(QUARTER));
				qaddr_s2[c] <= q[QADDR_BITS-1:0];
			end
		end
	end

	// Stage 3: quarter-wave table lookup. Stage 4: signed offset around mid level.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_level
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s3[c]   <= neg_s2[c];
				mag_s3[c]   <= peak_s2[c] ? SINE_PEAK : SINE_QTAB[qaddr_s2[c]];
				level_s4[c] <= neg_s3[c]
					? LEVEL_BITS'(LEVEL_MID) - LEVEL_BITS'(mag_s3[c])
					: LEVEL_BITS'(LEVEL_MID) + LEVEL_BITS'(mag_s3[c]);
			end
		end
	end

	// Valid bits of the last three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= dv_vld_s[NUM_DIV-1];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {level_s4[2], level_s4[1], level_s4[0]};

	// An accepted pixel always enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s1)
		else $error("accepted pixel did not enter the pipeline");

	// A stall freezes the divider tail.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (dv_vld_s[NUM_DIV-1] == $past(dv_vld_s[NUM_DIV-1])))
		else $error("divider moved during a stall");

	// The modulo remainder stays below the axis length.
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld_s[PROD_BITS-1] && (len != '0)) |-> (dv_rem_s[PROD_BITS-1] < len))
		else $error("modulo remainder out of range");

	// Output levels never exceed twice the mid level.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> ((level_s4[0] <= LEVEL_BITS'(2 * LEVEL_MID))
			&& (level_s4[1] <= LEVEL_BITS'(2 * LEVEL_MID))
			&& (level_s4[2] <= LEVEL_BITS'(2 * LEVEL_MID))))
		else $error("fringe level out of range");

endmodule

`default_nettype wire
